// ===== sv/gpd_pkg.sv =====
`timescale 1ns / 1ps

package gpd_pkg;

  localparam int MAX_COLS_DEF    = 1024;
  localparam int MAX_ROWS_DEF    = 1024;
  localparam int PIXEL_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int CFG_BITS       = 11;
  localparam int CFG_INDEX_BITS = 1;
  localparam int COORD_BITS     = 10;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FRAME_ROWS = 1'b0,
    REG_FRAME_COLS = 1'b1
  } cfg_reg_t;

  // decisions made for one pixel word, reported in this order
  localparam int HIT_UP   = 0;  // pixel above the one just taken
  localparam int HIT_LEFT = 1;  // last row, pixel to the left
  localparam int HIT_HERE = 2;  // last row, last column, the pixel itself
  localparam int HIT_BITS = 3;

  typedef logic [HIT_BITS-1:0] hits_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] col;
    hits_t                 hits;
  } entry_t;

endpackage

// ===== sv/gpd_pixel_if.sv =====
`timescale 1ns / 1ps

interface gpd_pixel_if #(
  parameter int PIXEL_BITS = gpd_pkg::PIXEL_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [PIXEL_BITS-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

// ===== sv/gpd_peak_if.sv =====
`timescale 1ns / 1ps

interface gpd_peak_if;
  logic                            valid;
  logic                            ready;
  logic [gpd_pkg::COORD_BITS-1:0]  peak_row;
  logic [gpd_pkg::COORD_BITS-1:0]  peak_col;
  logic                            last_of_run;

  modport source (output valid, output peak_row, output peak_col, output last_of_run,
                  input ready);
  modport sink   (input valid, input peak_row, input peak_col, input last_of_run,
                  output ready);
endinterface

// ===== sv/gpd_front.sv =====
`timescale 1ns / 1ps

module gpd_front #(
  parameter int MAX_COLS   = gpd_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS   = gpd_pkg::MAX_ROWS_DEF,
  parameter int PIXEL_BITS = gpd_pkg::PIXEL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [gpd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [gpd_pkg::CFG_BITS-1:0]        cfg_data,
  gpd_pixel_if.sink                           pixels,
  output logic                                push,
  output gpd_pkg::entry_t                     push_entry,
  input  logic                                queue_full
);

  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [gpd_pkg::CFG_BITS-1:0] frame_rows;
  logic [gpd_pkg::CFG_BITS-1:0] frame_cols;
  logic [RW-1:0]                rows_m1;
  logic [CW-1:0]                cols_m1;

  logic [RW-1:0] row_count;
  logic [CW-1:0] col_count;
  logic [RW-1:0] r;
  logic [CW-1:0] c;
  logic [CW-1:0] c_plus;

  logic signed [PIXEL_BITS-1:0] up_mem [MAX_COLS];
  logic signed [PIXEL_BITS-1:0] uu_mem [MAX_COLS];

  logic signed [PIXEL_BITS-1:0] rd_up;
  logic signed [PIXEL_BITS-1:0] rd_right;
  logic signed [PIXEL_BITS-1:0] rd_uu;
  logic signed [PIXEL_BITS-1:0] left_up;
  logic signed [PIXEL_BITS-1:0] prev_pixel;
  logic signed [PIXEL_BITS-1:0] prev_prev_pixel;

  logic                         s1_valid;
  logic [RW-1:0]                s1_row;
  logic [CW-1:0]                s1_col;
  logic signed [PIXEL_BITS-1:0] s1_pix;
  logic signed [PIXEL_BITS-1:0] s1_prev;
  logic signed [PIXEL_BITS-1:0] s1_prev2;
  logic                         s1_top;
  logic                         s1_top2;
  logic                         s1_c1;
  logic                         s1_c2;
  logic                         s1_last_row;
  logic                         s1_last_col;

  gpd_pkg::hits_t hits;
  logic           s1_move;
  logic           accept;

  // sizes outside the legal range are clamped
  always_comb begin
    if (frame_rows < gpd_pkg::CFG_BITS'(2)) begin
      rows_m1 = RW'(1);
    end else if (int'(frame_rows) > MAX_ROWS) begin
      rows_m1 = RW'(MAX_ROWS - 1);
    end else begin
      rows_m1 = RW'(frame_rows - gpd_pkg::CFG_BITS'(1));
    end
    if (frame_cols < gpd_pkg::CFG_BITS'(2)) begin
      cols_m1 = CW'(1);
    end else if (int'(frame_cols) > MAX_COLS) begin
      cols_m1 = CW'(MAX_COLS - 1);
    end else begin
      cols_m1 = CW'(frame_cols - gpd_pkg::CFG_BITS'(1));
    end
  end

  assign r      = (row_count > rows_m1) ? rows_m1 : row_count;
  assign c      = (col_count > cols_m1) ? cols_m1 : col_count;
  assign c_plus = c + CW'(1);

  // centre is the upper-line word read for this column
  always_comb begin
    hits = '0;
    hits[gpd_pkg::HIT_UP] = s1_top && (rd_up >= s1_pix)
                            && (!s1_top2 || rd_up >= rd_uu)
                            && (!s1_c1 || rd_up >= left_up)
                            && (s1_last_col || rd_up >= rd_right);
    hits[gpd_pkg::HIT_LEFT] = s1_last_row && s1_c1 && (s1_prev >= s1_pix)
                              && (s1_prev >= left_up)
                              && (!s1_c2 || s1_prev >= s1_prev2);
    hits[gpd_pkg::HIT_HERE] = s1_last_row && s1_last_col && (s1_pix >= s1_prev)
                              && (s1_pix >= rd_up);
  end

  assign s1_move      = s1_valid && ((hits == '0) || !queue_full);
  assign push         = s1_valid && (hits != '0) && !queue_full;
  assign pixels.ready = !s1_valid || s1_move;
  assign accept       = pixels.valid && pixels.ready;

  assign push_entry.row  = gpd_pkg::COORD_BITS'(s1_row);
  assign push_entry.col  = gpd_pkg::COORD_BITS'(s1_col);
  assign push_entry.hits = hits;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rows      <= gpd_pkg::CFG_BITS'(2);
      frame_cols      <= gpd_pkg::CFG_BITS'(2);
      row_count       <= '0;
      col_count       <= '0;
      prev_pixel      <= '0;
      prev_prev_pixel <= '0;
      s1_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (gpd_pkg::cfg_reg_t'(cfg_index))
          gpd_pkg::REG_FRAME_ROWS: frame_rows <= cfg_data;
          gpd_pkg::REG_FRAME_COLS: frame_cols <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        prev_pixel      <= pixels.pixel;
        prev_prev_pixel <= prev_pixel;
        if (c == cols_m1) begin
          col_count <= '0;
          row_count <= (r == rows_m1) ? '0 : r + RW'(1);
        end else begin
          col_count <= c_plus;
          row_count <= r;
        end
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // line stores: read before write at the same column
  always_ff @(posedge clk) begin
    if (accept) begin
      up_mem[c]   <= pixels.pixel;
      rd_up       <= up_mem[c];
      rd_right    <= up_mem[c_plus];
      rd_uu       <= uu_mem[c];
      s1_row      <= r;
      s1_col      <= c;
      s1_pix      <= pixels.pixel;
      s1_prev     <= prev_pixel;
      s1_prev2    <= prev_prev_pixel;
      s1_top      <= (r != '0);
      s1_top2     <= (r > RW'(1));
      s1_c1       <= (c != '0);
      s1_c2       <= (c > CW'(1));
      s1_last_row <= (r == rows_m1);
      s1_last_col <= (c == cols_m1);
    end
    if (s1_move) begin
      uu_mem[s1_col] <= rd_up;
      left_up        <= rd_up;
    end
  end

endmodule

// ===== sv/gpd_queue.sv =====
`timescale 1ns / 1ps

module gpd_queue #(
  parameter int DEPTH = gpd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  gpd_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output gpd_pkg::entry_t head,
  output logic            empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  gpd_pkg::entry_t slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [NW-1:0]   fill;

  assign full  = (fill == NW'(DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + NW'(1);
      end else if (pop && !push) begin
        fill <= fill - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

// ===== sv/gpd_back.sv =====
`timescale 1ns / 1ps

module gpd_back (
  input  logic            clk,
  input  logic            rst,
  input  gpd_pkg::entry_t head,
  input  logic            empty,
  output logic            pop,
  gpd_peak_if.source      peaks
);

  logic [gpd_pkg::COORD_BITS-1:0] w_row;
  logic [gpd_pkg::COORD_BITS-1:0] w_col;
  gpd_pkg::hits_t                 w_hits;
  gpd_pkg::hits_t                 sel;
  gpd_pkg::hits_t                 rest;
  logic                           emit;
  logic [gpd_pkg::COORD_BITS-1:0] sel_row;
  logic [gpd_pkg::COORD_BITS-1:0] sel_col;

  // lowest pending decision goes first
  assign sel  = w_hits & (~w_hits + gpd_pkg::hits_t'(1));
  assign rest = w_hits & ~sel;
  assign emit = (w_hits != '0) && (!peaks.valid || peaks.ready);
  assign pop  = !empty && ((w_hits == '0) || (emit && rest == '0));

  always_comb begin
    sel_row = w_row;
    sel_col = w_col;
    if (sel[gpd_pkg::HIT_UP]) begin
      sel_row = w_row - gpd_pkg::COORD_BITS'(1);
    end else if (sel[gpd_pkg::HIT_LEFT]) begin
      sel_col = w_col - gpd_pkg::COORD_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_hits      <= '0;
      peaks.valid <= 1'b0;
    end else begin
      if (pop) begin
        w_hits <= head.hits;
      end else if (emit) begin
        w_hits <= rest;
      end
      if (emit) begin
        peaks.valid <= 1'b1;
      end else if (peaks.ready) begin
        peaks.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      w_row <= head.row;
      w_col <= head.col;
    end
    if (emit) begin
      peaks.peak_row    <= sel_row;
      peaks.peak_col    <= sel_col;
      peaks.last_of_run <= (rest == '0);
    end
  end

endmodule

// ===== sv/grid_peak_detector_core.sv =====
`timescale 1ns / 1ps

// 4-neighbour local maximum detector over a raster-order pixel stream.
// pixels: valid/ready word channel, one signed pixel per word.
// peaks:  valid/ready word channel, row and column of each peak found;
//         last_of_run marks the final peak caused by one pixel word.
// cfg_we/cfg_index/cfg_data set frame_rows and frame_cols (2..MAX);
// the user must write them only while the block is idle; not enforced.
// Throughput: one pixel word per cycle while the queue has room, set by the
// single read/write pass over the two line stores per pixel. Rows above the
// last give at most one peak per pixel; the last row gives up to two (three
// for its last pixel), drained at one peak per cycle from the output
// register while the receiver is ready. A peak passes the front stage, a
// queue slot and the back-end working register into the output register.
// Reset clears counters, previous-pixel registers, the queue and the output
// register and sets a 2 x 2 frame; line stores are not cleared and need no
// clearing pass. When the receiver stalls the queue absorbs decisions;
// once full, pixels ready drops for words with hits until room returns.
module grid_peak_detector_core #(
  parameter int MAX_COLS    = gpd_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS    = gpd_pkg::MAX_ROWS_DEF,
  parameter int PIXEL_BITS  = gpd_pkg::PIXEL_BITS_DEF,
  parameter int QUEUE_DEPTH = gpd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [gpd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [gpd_pkg::CFG_BITS-1:0]        cfg_data,
  gpd_pixel_if.sink                           pixels,
  gpd_peak_if.source                          peaks
);

  logic            push;
  gpd_pkg::entry_t push_entry;
  logic            queue_full;
  logic            pop;
  gpd_pkg::entry_t head;
  logic            empty;

  gpd_front #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pixels     (pixels),
    .push       (push),
    .push_entry (push_entry),
    .queue_full (queue_full)
  );

  gpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head       (head),
    .empty      (empty)
  );

  gpd_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .peaks (peaks)
  );

endmodule

// ===== sv/gpd_checker.sv =====
`timescale 1ns / 1ps

module gpd_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [gpd_pkg::COORD_BITS-1:0] out_row,
  input logic [gpd_pkg::COORD_BITS-1:0] out_col,
  input logic                           out_last
);

  // a stalled peak word stays offered
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("peak word dropped while stalled");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_row) && $stable(out_col) && $stable(out_last))
    else $error("peak word changed while stalled");

  // reset empties the output register
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("peak offered right after reset");

  // reset leaves the front stage empty, so pixels are taken at once
  assert property (@(posedge clk) rst |=> in_ready)
    else $error("pixel channel not ready after reset");

endmodule

bind grid_peak_detector_core gpd_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pixels.ready),
  .out_valid (peaks.valid),
  .out_ready (peaks.ready),
  .out_row   (peaks.peak_row),
  .out_col   (peaks.peak_col),
  .out_last  (peaks.last_of_run)
);

// ===== verif/gpd_peak_monitor.sv =====
`timescale 1ns / 1ps

module gpd_peak_monitor (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_we,
  input  logic [gpd_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
  input  logic [gpd_pkg::CFG_BITS-1:0]             cfg_data,
  input  logic                                     pix_valid,
  input  logic                                     pix_ready,
  input  logic signed [gpd_pkg::PIXEL_BITS_DEF-1:0] pix_data,
  input  logic                                     pk_valid,
  input  logic                                     pk_ready,
  input  logic [gpd_pkg::COORD_BITS-1:0]           pk_row,
  input  logic [gpd_pkg::COORD_BITS-1:0]           pk_col,
  input  logic                                     pk_last,
  output int                                       mismatches,
  output int                                       outstanding
);

  typedef logic signed [gpd_pkg::PIXEL_BITS_DEF-1:0] pix_t;

  typedef struct packed {
    logic [gpd_pkg::COORD_BITS-1:0] row;
    logic [gpd_pkg::COORD_BITS-1:0] col;
    logic                           last;
  } peak_t;

  // two rows above, indexed by column
  pix_t                         line_above [gpd_pkg::MAX_COLS_DEF];
  pix_t                         line_above2 [gpd_pkg::MAX_COLS_DEF];
  pix_t                         left_pix;
  pix_t                         left_pix2;
  int                           row_pos;
  int                           col_pos;
  logic [gpd_pkg::CFG_BITS-1:0] rows_reg;
  logic [gpd_pkg::CFG_BITS-1:0] cols_reg;
  peak_t                        expected_peaks[$];
  peak_t                        want;

  function automatic int effective_size(input logic [gpd_pkg::CFG_BITS-1:0] v,
                                        input int limit);
    if (v < 2) return 2;
    if (int'(v) > limit) return limit;
    return int'(v);
  endfunction

  task automatic add_peak(input int r, input int c);
    peak_t e;
    e.row  = gpd_pkg::COORD_BITS'(r);
    e.col  = gpd_pkg::COORD_BITS'(c);
    e.last = 1'b0;
    expected_peaks.push_back(e);
  endtask

  // decisions caused by one pixel word, in reporting order
  task automatic decide_pixel(input pix_t p);
    int   m;
    int   n;
    int   r;
    int   c;
    int   found;
    pix_t ctr;
    logic ok;
    m = effective_size(rows_reg, gpd_pkg::MAX_ROWS_DEF);
    n = effective_size(cols_reg, gpd_pkg::MAX_COLS_DEF);
    // counters past a shrunken frame saturate to the last row/column
    r = (row_pos > m - 1) ? m - 1 : row_pos;
    c = (col_pos > n - 1) ? n - 1 : col_pos;
    found = 0;
    if (r >= 1) begin
      ctr = line_above[c];
      ok  = (ctr >= p);
      if (r >= 2 && ctr < line_above2[c]) ok = 1'b0;
      if (c >= 1 && ctr < line_above2[c-1]) ok = 1'b0;
      if (c + 1 < n && ctr < line_above[c+1]) ok = 1'b0;
      if (ok) begin
        add_peak(r - 1, c);
        found++;
      end
    end
    if (r == m - 1) begin
      if (c >= 1) begin
        // line_above2[c-1] already holds the pixel above the left one
        ok = (left_pix >= p) && (left_pix >= line_above2[c-1]);
        if (c >= 2 && left_pix < left_pix2) ok = 1'b0;
        if (ok) begin
          add_peak(r, c - 1);
          found++;
        end
      end
      if (c == n - 1 && p >= left_pix && p >= line_above[c]) begin
        add_peak(r, c);
        found++;
      end
    end
    if (found > 0) expected_peaks[expected_peaks.size()-1].last = 1'b1;
    line_above2[c] = line_above[c];
    line_above[c]  = p;
    left_pix2      = left_pix;
    left_pix       = p;
    if (c >= n - 1) begin
      col_pos = 0;
      row_pos = (r >= m - 1) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      left_pix   = '0;
      left_pix2  = '0;
      row_pos    = 0;
      col_pos    = 0;
      rows_reg   = gpd_pkg::CFG_BITS'(2);
      cols_reg   = gpd_pkg::CFG_BITS'(2);
      mismatches = 0;
      expected_peaks.delete();
    end else begin
      // a peak can never come from the pixel taken at this same edge
      if (pk_valid && pk_ready) begin
        if (expected_peaks.size() == 0) begin
          $error("unexpected peak word: row %0d col %0d last %0d", pk_row, pk_col, pk_last);
          mismatches++;
        end else begin
          want = expected_peaks.pop_front();
          if (pk_row !== want.row) begin
            $error("peak_row: expected %0d, got %0d", want.row, pk_row);
            mismatches++;
          end
          if (pk_col !== want.col) begin
            $error("peak_col: expected %0d, got %0d", want.col, pk_col);
            mismatches++;
          end
          if (pk_last !== want.last) begin
            $error("last_of_run: expected %0d, got %0d", want.last, pk_last);
            mismatches++;
          end
        end
      end
      if (cfg_we) begin
        case (gpd_pkg::cfg_reg_t'(cfg_index))
          gpd_pkg::REG_FRAME_ROWS: rows_reg = cfg_data;
          gpd_pkg::REG_FRAME_COLS: cols_reg = cfg_data;
          default: ;
        endcase
      end
      if (pix_valid && pix_ready) decide_pixel(pix_data);
    end
    outstanding = expected_peaks.size();
  end

endmodule

// ===== verif/grid_peak_detector_core_test.sv =====
`timescale 1ns / 1ps

module grid_peak_detector_core_test;

  typedef logic signed [gpd_pkg::PIXEL_BITS_DEF-1:0] pixel_word_t;

  localparam int SETTLE_CYCLES = 10;
  localparam int QUIET_LIMIT   = 2000;
  localparam int PHASE_PIXELS  = 125;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               cfg_we = 1'b0;
  logic [gpd_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [gpd_pkg::CFG_BITS-1:0]       cfg_data = '0;

  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  int mismatches;
  int outstanding;

  gpd_pixel_if pixels ();
  gpd_peak_if  peaks ();

  grid_peak_detector_core uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixels    (pixels),
    .peaks     (peaks)
  );

  gpd_peak_monitor peak_mon (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pix_valid   (pixels.valid),
    .pix_ready   (pixels.ready),
    .pix_data    (pixels.pixel),
    .pk_valid    (peaks.valid),
    .pk_ready    (peaks.ready),
    .pk_row      (peaks.peak_row),
    .pk_col      (peaks.peak_col),
    .pk_last     (peaks.last_of_run),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    peaks.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // ends the run if neither channel moves a word for too long
  always @(posedge clk) begin
    if ((pixels.valid && pixels.ready) || (peaks.valid && peaks.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic pixel_word_t random_pixel(input int style);
    case (style)
      0: return pixel_word_t'($urandom);
      1: return pixel_word_t'($urandom_range(0, 4)) - pixel_word_t'(2);
      default: return $urandom_range(0, 1) ? pixel_word_t'(16'h7FFF) : pixel_word_t'(16'h8000);
    endcase
  endfunction

  task automatic send_pixel(input pixel_word_t v);
    logic taken;
    while ($urandom_range(0, 99) < idle_pct) begin
      pixels.valid <= 1'b0;
      @(posedge clk);
    end
    pixels.valid <= 1'b1;
    pixels.pixel <= v;
    // ready is stable by the falling edge
    forever begin
      @(negedge clk);
      taken = pixels.ready;
      @(posedge clk);
      if (taken) break;
    end
  endtask

  // stop the stream and let the block drain before touching the registers
  task automatic wait_idle;
    pixels.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_frame_size(input logic [gpd_pkg::CFG_BITS-1:0] rows,
                                  input logic [gpd_pkg::CFG_BITS-1:0] cols);
    cfg_we    <= 1'b1;
    cfg_index <= gpd_pkg::REG_FRAME_ROWS;
    cfg_data  <= rows;
    @(posedge clk);
    cfg_index <= gpd_pkg::REG_FRAME_COLS;
    cfg_data  <= cols;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int                           mode;
    int                           phase_pixels;
    int                           i;
    int                           rows_eff;
    int                           cols_eff;
    int                           shape;
    int                           style;
    logic [gpd_pkg::CFG_BITS-1:0] rows_val;
    logic [gpd_pkg::CFG_BITS-1:0] cols_val;

    pixels.valid = 1'b0;
    pixels.pixel = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset frame is 2 x 2: extremes, then all ties (three peaks on the last word)
    send_pixel(pixel_word_t'(16'h7FFF));
    send_pixel(pixel_word_t'(16'h8000));
    send_pixel(pixel_word_t'(16'h8000));
    send_pixel(pixel_word_t'(16'h7FFF));
    repeat (4) send_pixel('0);

    // tallest frame, cut short by shrinking rows below the current row
    wait_idle();
    write_frame_size(gpd_pkg::CFG_BITS'(2047), gpd_pkg::CFG_BITS'(3));
    repeat (10) send_pixel(random_pixel(1));
    wait_idle();
    write_frame_size(gpd_pkg::CFG_BITS'(0), gpd_pkg::CFG_BITS'(3));
    repeat (2) send_pixel(random_pixel(1));

    // widest row, cut short by shrinking columns; rows below the minimum
    wait_idle();
    write_frame_size(gpd_pkg::CFG_BITS'(1), gpd_pkg::CFG_BITS'(2047));
    repeat (4) send_pixel(random_pixel(1));
    wait_idle();
    write_frame_size(gpd_pkg::CFG_BITS'(1), gpd_pkg::CFG_BITS'(3));
    repeat (4) send_pixel(random_pixel(1));

    for (mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 48; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 48; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      phase_pixels = 0;
      while (phase_pixels < PHASE_PIXELS) begin
        shape = $urandom_range(0, 9);
        if (shape == 0) begin
          rows_eff = $urandom_range(2, 3);
          cols_eff = $urandom_range(30, 100);
        end else if (shape == 1) begin
          rows_eff = $urandom_range(20, 50);
          cols_eff = 2;
        end else begin
          rows_eff = $urandom_range(2, 6);
          cols_eff = $urandom_range(2, 10);
        end
        rows_val = gpd_pkg::CFG_BITS'(rows_eff);
        cols_val = gpd_pkg::CFG_BITS'(cols_eff);
        // sizes below two act as two
        if (rows_eff == 2 && $urandom_range(0, 3) == 0)
          rows_val = gpd_pkg::CFG_BITS'($urandom_range(0, 1));
        if (cols_eff == 2 && $urandom_range(0, 3) == 0)
          cols_val = gpd_pkg::CFG_BITS'($urandom_range(0, 1));
        style = $urandom_range(0, 2);
        wait_idle();
        write_frame_size(rows_val, cols_val);
        for (i = 0; i < rows_eff * cols_eff; i++) send_pixel(random_pixel(style));
        phase_pixels += rows_eff * cols_eff;
      end
    end

    wait_idle();
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
sv/gpd_pkg.sv
sv/gpd_pixel_if.sv
sv/gpd_peak_if.sv
sv/gpd_front.sv
sv/gpd_queue.sv
sv/gpd_back.sv
sv/grid_peak_detector_core.sv
sv/gpd_checker.sv
verif/gpd_peak_monitor.sv
verif/grid_peak_detector_core_test.sv
